/* sv/pcm_pkg.sv */
// Shared constants, command/status structs and multiplier op codes for the
// population central moments block. No dependencies.
package pcm_pkg;

    localparam int COUNT_BITS = 16;
    localparam int CNT_W      = 16;
    localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'((64'd1 << COUNT_BITS) - 64'd1);

    localparam int FIT_W  = 12;
    localparam int MUT_W  = 8;
    localparam int MEAN_W = 12;
    localparam int R2_W   = 24;
    localparam int R3_W   = 36;
    localparam int R4_W   = 48;

    localparam int VAR_W = 26;
    localparam int C3_W  = 40;
    localparam int C4_W  = 52;
    localparam int MOM_W = 56;

    localparam int DIV_W     = 64;
    localparam int DIV_STEPS = DIV_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int NUM_DIV   = 8;
    localparam int SEL_W     = $clog2(NUM_DIV);

    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 24;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 280;

    // quotient slots, in divider order
    localparam logic [SEL_W-1:0] SEL_FM  = 3'd0;
    localparam logic [SEL_W-1:0] SEL_FR2 = 3'd1;
    localparam logic [SEL_W-1:0] SEL_FR3 = 3'd2;
    localparam logic [SEL_W-1:0] SEL_FR4 = 3'd3;
    localparam logic [SEL_W-1:0] SEL_MM  = 3'd4;
    localparam logic [SEL_W-1:0] SEL_MR2 = 3'd5;
    localparam logic [SEL_W-1:0] SEL_MR3 = 3'd6;
    localparam logic [SEL_W-1:0] SEL_MR4 = 3'd7;

    typedef enum logic [2:0] {
        MUL_M2,
        MUL_M3,
        MUL_M4,
        MUL_P1,
        MUL_P2,
        MUL_P3
    } mul_op_t;

    typedef struct packed {
        logic             div_load;
        logic             div_step;
        logic             div_store;
        logic [SEL_W-1:0] div_sel;
        logic             mul_en;
        mul_op_t          mul_op;
        logic             side;
        logic             comb_en;
        logic             out_load;
    } pcm_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic cnt_zero;
        logic out_free;
    } pcm_stat_t;

endpackage

/* sv/pcm_ctrl.sv */
// Sequencer for the moments block: accumulate, drain, divide, multiply,
// combine, hand off. Depends on pcm_pkg.
module pcm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    output logic              s_tready,
    input  pcm_pkg::pcm_stat_t stat,
    output pcm_pkg::pcm_cmd_t  cmd
);
    import pcm_pkg::*;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_DRAIN,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_DIV_STORE,
        ST_MUL,
        ST_COMB,
        ST_WAIT_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SEL_W-1:0]  sel_reg, sel_next;
    mul_op_t           op_reg, op_next;
    logic              side_reg, side_next;
    logic              ready_reg;
    logic              in_acc;

    assign in_acc   = s_tvalid && ready_reg;
    assign s_tready = ready_reg;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        sel_next   = sel_reg;
        op_next    = op_reg;
        side_next  = side_reg;
        case (state_reg)
            ST_ACCUM: begin
                if (in_acc && s_tlast) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!stat.pipe_busy) begin
                    sel_next   = '0;
                    state_next = stat.cnt_zero ? ST_WAIT_OUT : ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD: begin
                step_next  = '0;
                state_next = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = ST_DIV_STORE;
                end
            end
            ST_DIV_STORE: begin
                if (sel_reg == SEL_W'(NUM_DIV - 1)) begin
                    op_next    = MUL_M2;
                    side_next  = 1'b0;
                    state_next = ST_MUL;
                end else begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_MUL: begin
                case (op_reg)
                    MUL_M2:  op_next = MUL_M3;
                    MUL_M3:  op_next = MUL_M4;
                    MUL_M4:  op_next = MUL_P1;
                    MUL_P1:  op_next = MUL_P2;
                    MUL_P2:  op_next = MUL_P3;
                    default: state_next = ST_COMB;
                endcase
            end
            ST_COMB: begin
                if (side_reg) begin
                    state_next = ST_WAIT_OUT;
                end else begin
                    side_next  = 1'b1;
                    op_next    = MUL_M2;
                    state_next = ST_MUL;
                end
            end
            ST_WAIT_OUT: begin
                if (stat.out_free) begin
                    state_next = ST_ACCUM;
                end
            end
            default: state_next = ST_ACCUM;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCUM;
            step_reg  <= '0;
            sel_reg   <= '0;
            op_reg    <= MUL_M2;
            side_reg  <= 1'b0;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sel_reg   <= sel_next;
            op_reg    <= op_next;
            side_reg  <= side_next;
            ready_reg <= (state_next == ST_ACCUM);
        end
    end

    always_comb begin
        cmd.div_load  = (state_reg == ST_DIV_LOAD);
        cmd.div_step  = (state_reg == ST_DIV_RUN);
        cmd.div_store = (state_reg == ST_DIV_STORE);
        cmd.div_sel   = sel_reg;
        cmd.mul_en    = (state_reg == ST_MUL);
        cmd.mul_op    = op_reg;
        cmd.side      = side_reg;
        cmd.comb_en   = (state_reg == ST_COMB);
        cmd.out_load  = (state_reg == ST_WAIT_OUT) && stat.out_free;
    end

endmodule

/* sv/pcm_datapath.sv */
// Datapath: power-sum accumulator pipeline, serial divider, shared multiplier,
// moment combine and output register. Depends on pcm_pkg.
module pcm_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_acc,
    input  logic [pcm_pkg::FIT_W-1:0]       fitness_value,
    input  logic [pcm_pkg::MUT_W-1:0]       mutation_count,
    input  logic                            has_sample,
    input  pcm_pkg::pcm_cmd_t               cmd,
    output pcm_pkg::pcm_stat_t              stat,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [pcm_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tuser
);
    import pcm_pkg::*;

    localparam logic signed [MOM_W-1:0] VAR_LIM = MOM_W'(64'd1 << 24);
    localparam logic signed [MOM_W-1:0] C3_LIM  = MOM_W'(64'd1 << 38);
    localparam logic signed [MOM_W-1:0] C4_LIM  = MOM_W'(64'd1 << 50);

    function automatic logic signed [MOM_W-1:0] clamp_sym(
        input logic signed [MOM_W-1:0] v,
        input logic signed [MOM_W-1:0] lim
    );
        logic signed [MOM_W-1:0] r;
        r = v;
        if (v > lim) r = lim;
        if (v < -lim) r = -lim;
        return r;
    endfunction

    // ---------------- accumulation ----------------
    logic [CNT_W-1:0] cnt_reg;
    logic             drop_reg;
    logic             take;
    logic             v1_reg, v2_reg, v3_reg;
    logic [FIT_W-1:0] f1_reg;
    logic [MUT_W-1:0] u1_reg;
    logic [FIT_W-1:0] f2_reg;
    logic [MUT_W-1:0] u2_reg;
    logic [23:0]      fsq2_reg, fsq3_reg;
    logic [15:0]      usq2_reg, usq3_reg;
    logic [FIT_W-1:0] f3_reg;
    logic [MUT_W-1:0] u3_reg;
    logic [35:0]      fcube_reg;
    logic [47:0]      ffour_reg;
    logic [23:0]      ucube_reg;
    logic [31:0]      ufour_reg;
    logic [27:0]      fs1_reg;
    logic [39:0]      fs2_reg;
    logic [51:0]      fs3_reg;
    logic [63:0]      fs4_reg;
    logic [23:0]      ms1_reg;
    logic [31:0]      ms2_reg;
    logic [39:0]      ms3_reg;
    logic [47:0]      ms4_reg;

    assign take = in_acc && has_sample && (cnt_reg < COUNT_LIMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.out_load) begin
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
            fs1_reg  <= '0;
            fs2_reg  <= '0;
            fs3_reg  <= '0;
            fs4_reg  <= '0;
            ms1_reg  <= '0;
            ms2_reg  <= '0;
            ms3_reg  <= '0;
            ms4_reg  <= '0;
        end else begin
            if (take) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (in_acc && has_sample) begin
                drop_reg <= 1'b1;
            end
            if (v3_reg) begin
                fs1_reg <= fs1_reg + 28'(f3_reg);
                fs2_reg <= fs2_reg + 40'(fsq3_reg);
                fs3_reg <= fs3_reg + 52'(fcube_reg);
                fs4_reg <= fs4_reg + 64'(ffour_reg);
                ms1_reg <= ms1_reg + 24'(u3_reg);
                ms2_reg <= ms2_reg + 32'(usq3_reg);
                ms3_reg <= ms3_reg + 40'(ucube_reg);
                ms4_reg <= ms4_reg + 48'(ufour_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        f1_reg    <= fitness_value;
        u1_reg    <= mutation_count;
        f2_reg    <= f1_reg;
        u2_reg    <= u1_reg;
        fsq2_reg  <= 24'(f1_reg) * 24'(f1_reg);
        usq2_reg  <= 16'(u1_reg) * 16'(u1_reg);
        f3_reg    <= f2_reg;
        u3_reg    <= u2_reg;
        fsq3_reg  <= fsq2_reg;
        usq3_reg  <= usq2_reg;
        fcube_reg <= 36'(fsq2_reg) * 36'(f2_reg);
        ffour_reg <= 48'(fsq2_reg) * 48'(fsq2_reg);
        ucube_reg <= 24'(usq2_reg) * 24'(u2_reg);
        ufour_reg <= 32'(usq2_reg) * 32'(usq2_reg);
    end

    // ---------------- serial divider: one quotient bit per cycle ----------------
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] dq_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W:0]   rem_sh, rem_sub;
    logic             q_bit;

    always_comb begin
        case (cmd.div_sel)
            SEL_FM:  dividend = DIV_W'(fs1_reg);
            SEL_FR2: dividend = DIV_W'(fs2_reg);
            SEL_FR3: dividend = DIV_W'(fs3_reg);
            SEL_FR4: dividend = fs4_reg;
            SEL_MM:  dividend = DIV_W'({ms1_reg, 4'b0});
            SEL_MR2: dividend = DIV_W'({ms2_reg, 8'b0});
            SEL_MR3: dividend = DIV_W'({ms3_reg, 12'b0});
            SEL_MR4: dividend = {ms4_reg, 16'b0};
            default: dividend = '0;
        endcase
    end

    assign rem_sh  = {rem_reg, dq_reg[DIV_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, cnt_reg});
    assign rem_sub = q_bit ? (rem_sh - {1'b0, cnt_reg}) : rem_sh;

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            dq_reg  <= dividend;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            dq_reg  <= {dq_reg[DIV_W-2:0], q_bit};
            rem_reg <= rem_sub[CNT_W-1:0];
        end
    end

    logic [MEAN_W-1:0] fm_reg, mm_reg;
    logic [R2_W-1:0]   fr2_reg, mr2_reg;
    logic [R3_W-1:0]   fr3_reg, mr3_reg;
    logic [R4_W-1:0]   fr4_reg, mr4_reg;

    always_ff @(posedge aclk) begin
        if (cmd.div_store) begin
            case (cmd.div_sel)
                SEL_FM:  fm_reg  <= dq_reg[MEAN_W-1:0];
                SEL_FR2: fr2_reg <= dq_reg[R2_W-1:0];
                SEL_FR3: fr3_reg <= dq_reg[R3_W-1:0];
                SEL_FR4: fr4_reg <= dq_reg[R4_W-1:0];
                SEL_MM:  mm_reg  <= dq_reg[MEAN_W-1:0];
                SEL_MR2: mr2_reg <= dq_reg[R2_W-1:0];
                SEL_MR3: mr3_reg <= dq_reg[R3_W-1:0];
                SEL_MR4: mr4_reg <= dq_reg[R4_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- shared multiplier ----------------
    logic [MEAN_W-1:0]          m_cur;
    logic [R2_W-1:0]            r2_cur;
    logic [R3_W-1:0]            r3_cur;
    logic [R4_W-1:0]            r4_cur;
    logic [MUL_A_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic [MUL_A_W+MUL_B_W-1:0] prod;
    logic [23:0]                m2_reg;
    logic [35:0]                m3_reg, p1_reg;
    logic [47:0]                m4_reg, p2_reg, p3_reg;

    assign m_cur  = cmd.side ? mm_reg  : fm_reg;
    assign r2_cur = cmd.side ? mr2_reg : fr2_reg;
    assign r3_cur = cmd.side ? mr3_reg : fr3_reg;
    assign r4_cur = cmd.side ? mr4_reg : fr4_reg;

    always_comb begin
        case (cmd.mul_op)
            MUL_M2: begin
                mul_a = MUL_A_W'(m_cur);
                mul_b = MUL_B_W'(m_cur);
            end
            MUL_M3: begin
                mul_a = MUL_A_W'(m_cur);
                mul_b = m2_reg;
            end
            MUL_M4: begin
                mul_a = m3_reg;
                mul_b = MUL_B_W'(m_cur);
            end
            MUL_P1: begin
                mul_a = MUL_A_W'(m_cur);
                mul_b = r2_cur;
            end
            MUL_P2: begin
                mul_a = r3_cur;
                mul_b = MUL_B_W'(m_cur);
            end
            MUL_P3: begin
                mul_a = MUL_A_W'(m2_reg);
                mul_b = r2_cur;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = (MUL_A_W + MUL_B_W)'(mul_a) * (MUL_A_W + MUL_B_W)'(mul_b);

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            case (cmd.mul_op)
                MUL_M2:  m2_reg <= prod[23:0];
                MUL_M3:  m3_reg <= prod[35:0];
                MUL_M4:  m4_reg <= prod[47:0];
                MUL_P1:  p1_reg <= prod[35:0];
                MUL_P2:  p2_reg <= prod[47:0];
                MUL_P3:  p3_reg <= prod[47:0];
                default: ;
            endcase
        end
    end

    // ---------------- combine ----------------
    logic signed [MOM_W-1:0] var_v, c3_v, c4_v;
    logic signed [MOM_W-1:0] var_c, c3_c, c4_c;
    logic [VAR_W-1:0]        fvar_reg, mvar_reg;
    logic [C3_W-1:0]         fc3_reg, mc3_reg;
    logic [C4_W-1:0]         fc4_reg, mc4_reg;

    always_comb begin
        var_v = MOM_W'(r2_cur) - MOM_W'(m2_reg);
        // r3 - 3*m*r2 + 2*m^3
        c3_v  = MOM_W'(r3_cur) - (MOM_W'(p1_reg) << 1) - MOM_W'(p1_reg)
                + (MOM_W'(m3_reg) << 1);
        // r4 - 4*m*r3 + 6*m^2*r2 - 3*m^4
        c4_v  = MOM_W'(r4_cur) - (MOM_W'(p2_reg) << 2)
                + (MOM_W'(p3_reg) << 2) + (MOM_W'(p3_reg) << 1)
                - (MOM_W'(m4_reg) << 1) - MOM_W'(m4_reg);
        var_c = clamp_sym(var_v, VAR_LIM);
        c3_c  = clamp_sym(c3_v, C3_LIM);
        c4_c  = clamp_sym(c4_v, C4_LIM);
    end

    always_ff @(posedge aclk) begin
        if (cmd.comb_en) begin
            if (cmd.side) begin
                mvar_reg <= var_c[VAR_W-1:0];
                mc3_reg  <= c3_c[C3_W-1:0];
                mc4_reg  <= c4_c[C4_W-1:0];
            end else begin
                fvar_reg <= var_c[VAR_W-1:0];
                fc3_reg  <= c3_c[C3_W-1:0];
                fc4_reg  <= c4_c[C4_W-1:0];
            end
        end
    end

    // ---------------- output register ----------------
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_user_reg;
    logic                 zero_pop;

    assign zero_pop = (cnt_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_user_reg <= drop_reg;
            if (zero_pop) begin
                out_data_reg <= '0;
            end else begin
                out_data_reg <= {4'b0, mc4_reg, mc3_reg, mvar_reg, mm_reg,
                                 fc4_reg, fc3_reg, fvar_reg, fm_reg, cnt_reg};
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    assign stat.pipe_busy = v1_reg || v2_reg || v3_reg;
    assign stat.cnt_zero  = zero_pop;
    assign stat.out_free  = !out_valid_reg || m_tready;

endmodule

/* sv/population_central_moments.sv */
// Population central moments: one sample item per cycle while accumulating.
// Result valid after the last item once the accumulator pipeline has drained:
// eight 64-step divisions by the count, 2x(6 multiplies + combine), output load;
// empty population: output load only. Input is blocked from the last item until the
// result is loaded into the output register, so populations do not overlap.
// Reset: aresetn synchronous, active low; clears count, sums, flags and valids.
module population_central_moments (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [11:0] fitness_value, [19:12] mutation_count, [23:20] zero
    input  logic [pcm_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] has_sample
    input  logic                            s_tuser,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] sample_count, [27:16] fitness_mean, [53:28] fitness_second_moment,
    // [93:54] fitness_third_moment, [145:94] fitness_fourth_moment,
    // [157:146] mutation_mean, [183:158] mutation_variance,
    // [223:184] mutation_third_moment, [275:224] mutation_fourth_moment,
    // [279:276] zero
    output logic [pcm_pkg::M_TDATA_W-1:0]   m_tdata,
    // [0] count_overflow
    output logic                            m_tuser
);
    import pcm_pkg::*;

    pcm_cmd_t  cmd;
    pcm_stat_t stat;
    logic      in_acc;

    assign in_acc = s_tvalid && s_tready;

    pcm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pcm_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_acc         (in_acc),
        .fitness_value  (s_tdata[FIT_W-1:0]),
        .mutation_count (s_tdata[FIT_W+MUT_W-1:FIT_W]),
        .has_sample     (s_tuser),
        .cmd            (cmd),
        .stat           (stat),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser)
    );

`ifndef ASSERT_OFF
    a_block_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still open after last item");

    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[CNT_W-1:0] == COUNT_LIMIT))
        else $error("overflow flagged below count limit");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[CNT_W-1:0] == '0)) |-> (m_tdata[M_TDATA_W-1:CNT_W] == '0))
        else $error("empty population with nonzero moments");

    a_load_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !s_tready)
        else $error("result loaded while input open");
`endif

endmodule

/* tb/tb_population_central_moments.sv */
// Self-checking testbench for population_central_moments: stream items in,
// predict moment results in a scoreboard class, compare every result item.
// Depends on pcm_pkg and the population_central_moments RTL.
module tb_population_central_moments;
    timeunit 1ns;
    timeprecision 1ps;

    import pcm_pkg::*;

    localparam int HOLD_CYCLES  = 2000;
    localparam int STALL_LIMIT  = 12000;
    localparam int DRAIN_CYCLES = 700;
    localparam int RANDOM_ITEMS = 800;

    typedef struct packed {
        logic [15:0] count;
        logic [11:0] f_mean;
        logic [25:0] f_var;
        logic [39:0] f_c3;
        logic [51:0] f_c4;
        logic [11:0] m_mean;
        logic [25:0] m_var;
        logic [39:0] m_c3;
        logic [51:0] m_c4;
        logic        dropped;
    } moments_t;

    class moment_scoreboard;
        longint unsigned samples;
        longint unsigned fs1, fs2, fs3, fs4;
        longint unsigned ms1, ms2, ms3, ms4;
        bit              dropped;
        moments_t        expected_q[$];
        int              mismatches;

        function new();
            clear();
            mismatches = 0;
        endfunction

        function void clear();
            samples = 0;
            fs1 = 0; fs2 = 0; fs3 = 0; fs4 = 0;
            ms1 = 0; ms2 = 0; ms3 = 0; ms4 = 0;
            dropped = 0;
        endfunction

        function longint clamp(longint v, longint lim);
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        // m and r_k share one scale; products wrap at 64 bits
        function void central(longint m, longint r2, longint r3, longint r4,
                              output longint var_o, output longint c3,
                              output longint c4);
            longint m2, m3, m4;
            m2 = m * m;
            m3 = m2 * m;
            m4 = m3 * m;
            var_o = clamp(r2 - m2, 64'sd1 <<< 24);
            c3 = clamp(r3 - 3 * m * r2 + 2 * m3, 64'sd1 <<< 38);
            c4 = clamp(r4 - 4 * m * r3 + 6 * m2 * r2 - 3 * m4, 64'sd1 <<< 50);
        endfunction

        function void note_item(logic [11:0] fit, logic [7:0] mut, logic has, logic last);
            longint unsigned f, mu, f2, m2;
            longint fm, fr2, fr3, fr4, mm, mr2, mr3, mr4;
            longint fv, fc3, fc4, mv, mc3, mc4;
            moments_t r;
            f = fit;
            mu = mut;
            if (has) begin
                if (samples < 64'hFFFF) begin
                    f2 = f * f;
                    m2 = mu * mu;
                    fs1 = (fs1 + f) & ((64'd1 << 28) - 1);
                    fs2 = (fs2 + f2) & ((64'd1 << 40) - 1);
                    fs3 = (fs3 + f2 * f) & ((64'd1 << 52) - 1);
                    fs4 = fs4 + f2 * f2;
                    ms1 = (ms1 + mu) & ((64'd1 << 24) - 1);
                    ms2 = (ms2 + m2) & ((64'd1 << 32) - 1);
                    ms3 = (ms3 + m2 * mu) & ((64'd1 << 40) - 1);
                    ms4 = (ms4 + m2 * m2) & ((64'd1 << 48) - 1);
                    samples++;
                end else begin
                    dropped = 1;
                end
            end
            if (!last) return;
            fm = 0; fv = 0; fc3 = 0; fc4 = 0;
            mm = 0; mv = 0; mc3 = 0; mc4 = 0;
            if (samples != 0) begin
                fm  = longint'(fs1 / samples);
                fr2 = longint'(fs2 / samples);
                fr3 = longint'(fs3 / samples);
                fr4 = longint'(fs4 / samples);
                mm  = longint'((ms1 << 4) / samples);
                mr2 = longint'((ms2 << 8) / samples);
                mr3 = longint'((ms3 << 12) / samples);
                mr4 = longint'((ms4 << 16) / samples);
                central(fm, fr2, fr3, fr4, fv, fc3, fc4);
                central(mm, mr2, mr3, mr4, mv, mc3, mc4);
            end
            r.count   = samples[15:0];
            r.f_mean  = fm[11:0];
            r.f_var   = fv[25:0];
            r.f_c3    = fc3[39:0];
            r.f_c4    = fc4[51:0];
            r.m_mean  = mm[11:0];
            r.m_var   = mv[25:0];
            r.m_c3    = mc3[39:0];
            r.m_c4    = mc4[51:0];
            r.dropped = dropped;
            expected_q.insert(expected_q.size(), r);
            clear();
        endfunction

        function void report(string name, logic [63:0] exp_v, logic [63:0] act_v);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s expected %h got %h", $realtime, name, exp_v, act_v);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] d, logic flag);
            moments_t e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result item %h", $realtime, d);
                return;
            end
            e = expected_q.pop_front();
            if (d[15:0] !== e.count)     report("sample_count", e.count, d[15:0]);
            if (d[27:16] !== e.f_mean)   report("fitness_mean", e.f_mean, d[27:16]);
            if (d[53:28] !== e.f_var)    report("fitness_second_moment", e.f_var, d[53:28]);
            if (d[93:54] !== e.f_c3)     report("fitness_third", e.f_c3, d[93:54]);
            if (d[145:94] !== e.f_c4)    report("fitness_fourth", e.f_c4, d[145:94]);
            if (d[157:146] !== e.m_mean) report("mutation_mean", e.m_mean, d[157:146]);
            if (d[183:158] !== e.m_var)  report("mutation_variance", e.m_var, d[183:158]);
            if (d[223:184] !== e.m_c3)   report("mutation_third", e.m_c3, d[223:184]);
            if (d[275:224] !== e.m_c4)   report("mutation_fourth", e.m_c4, d[275:224]);
            if (flag !== e.dropped)      report("count_overflow", e.dropped, flag);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 s_tvalid = 0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 0;
    logic                 s_tlast = 0;
    logic                 m_tvalid;
    logic                 m_tready = 0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    moment_scoreboard sb = new();
    int  idle_pct = 0;
    int  stall_pct = 0;
    bit  hold_off = 0;
    int  quiet_cycles = 0;

    population_central_moments dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_item(s_tdata[11:0], s_tdata[19:12], s_tuser, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("population_central_moments: mismatch");
                $finish;
            end
        end
    end

    task automatic send_item(logic [11:0] fit, logic [7:0] mut, logic has, logic last);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, mut, fit};
        s_tuser  <= has;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // population of n random samples, the last flagged last; n == 0 sends a bare end marker
    task automatic send_population(int n, int noise_pct);
        int i;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(99) < noise_pct)
                send_item(12'($urandom), 8'($urandom), 1'b0, 1'b0);
            send_item(12'($urandom), 8'($urandom), 1'b1, (i == n - 1));
        end
        if (n == 0)
            send_item(12'($urandom), 8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        int i, sent;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off = 0;
            end
        join_none

        // directed: empty set, no-op item, extremes, sample on last
        send_item(12'hFFF, 8'hFF, 1'b0, 1'b0);
        send_item(12'h000, 8'h00, 1'b0, 1'b1);
        send_item(12'h000, 8'h00, 1'b1, 1'b1);
        send_item(12'hFFF, 8'hFF, 1'b1, 1'b1);
        for (i = 0; i < 4; i++) send_item(12'hFFF, 8'hFF, 1'b1, i == 3);
        send_item(12'h000, 8'h00, 1'b1, 1'b0);
        send_item(12'hFFF, 8'hFF, 1'b1, 1'b0);
        send_item(12'h000, 8'h00, 1'b1, 1'b0);
        send_item(12'hFFF, 8'hFF, 1'b1, 1'b0);
        send_item(12'h000, 8'h00, 1'b0, 1'b1);
        send_item(12'hAAA, 8'hAA, 1'b1, 1'b0);
        send_item(12'h555, 8'h55, 1'b1, 1'b0);
        send_item(12'h001, 8'h01, 1'b1, 1'b1);
        send_item(12'hFFF, 8'h00, 1'b1, 1'b0);
        send_item(12'h000, 8'hFF, 1'b1, 1'b0);
        send_item(12'h800, 8'h80, 1'b1, 1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 54 : (ph == 3) ? 23 : 0;
            stall_pct = (ph == 2) ? 54 : (ph == 3) ? 23 : 0;
            sent = 0;
            while (sent < RANDOM_ITEMS / 4) begin
                i = ($urandom_range(19) == 0) ? 0 :
                    ($urandom_range(9) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 8);
                if ($urandom_range(15) == 0) begin
                    // sample, then bare end marker
                    send_item(12'($urandom), 8'($urandom), 1'b1, 1'b0);
                    send_item(12'($urandom), 8'($urandom), 1'b0, 1'b1);
                    i = 2;
                end else begin
                    send_population(i, 10);
                end
                sent += (i == 0) ? 1 : i;
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("population_central_moments: match");
        else
            $display("population_central_moments: mismatch");
        $finish;
    end
endmodule

/* files.f */
sv/pcm_pkg.sv
sv/pcm_ctrl.sv
sv/pcm_datapath.sv
sv/population_central_moments.sv
tb/tb_population_central_moments.sv
